// ----- rtl/uats_pkg.sv -----
package uats_pkg;

  // parser modes; unused codes behave as idle
  typedef enum logic [3:0] {
    MODE_IDLE  = 4'd0,
    MODE_UTF   = 4'd1,
    MODE_ESC   = 4'd2,
    MODE_SSARG = 4'd3,
    MODE_STR   = 4'd4,
    MODE_SOS   = 4'd5,
    MODE_CSI   = 4'd6
  } mode_t;

  // token kinds
  localparam logic [1:0] KIND_CTRL  = 2'd0;
  localparam logic [1:0] KIND_ASCII = 2'd1;
  localparam logic [1:0] KIND_UTF8  = 2'd2;
  localparam logic [1:0] KIND_ESC   = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_CONT_LEAD = 3'd1;
  localparam logic [2:0] ST_BAD_LEAD  = 3'd2;
  localparam logic [2:0] ST_PRIVATE   = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;

  // byte values
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } step_in_t;

  typedef struct packed {
    logic [7:0] data;
    logic       token_end;
    logic [1:0] kind;
    logic [2:0] status;
  } result_t;

endpackage

// ----- rtl/uats_core.sv -----
module uats_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  uats_pkg::step_in_t step_in,
  output logic              emit,
  output uats_pkg::result_t res
);

  uats_pkg::mode_t mode_r, mode_nxt;
  logic [1:0] left_r, left_nxt;
  logic       saw_esc_r, saw_esc_nxt;
  logic       drop_r, drop_nxt;

  always_comb begin
    logic [7:0] b;
    logic       eos;
    logic       tok_end;
    logic       fail;
    logic [1:0] kind;
    logic [2:0] st;
    logic [1:0] left_dec;
    logic       intro;

    b        = step_in.data;
    eos      = step_in.eos;
    tok_end  = 1'b0;
    fail     = 1'b0;
    kind     = uats_pkg::KIND_ESC;
    st       = uats_pkg::ST_OK;
    left_dec = left_r - 2'd1;
    intro    = 1'b0;

    mode_nxt    = mode_r;
    left_nxt    = left_r;
    saw_esc_nxt = saw_esc_r;
    drop_nxt    = drop_r;
    emit        = 1'b0;

    if (drop_r) begin
      if (eos) begin
        drop_nxt    = 1'b0;
        mode_nxt    = uats_pkg::MODE_IDLE;
        left_nxt    = 2'd0;
        saw_esc_nxt = 1'b0;
      end
    end else begin
      emit = 1'b1;
      unique case (mode_r)
        uats_pkg::MODE_UTF: begin
          kind = uats_pkg::KIND_UTF8;
          if (left_dec == 2'd0) begin
            tok_end = 1'b1;
          end else if (eos) begin
            tok_end = 1'b1;
            fail    = 1'b1;
            st      = uats_pkg::ST_TRUNC;
          end else begin
            left_nxt = left_dec;
          end
        end
        uats_pkg::MODE_ESC: begin
          priority if (b == uats_pkg::CH_N || b == uats_pkg::CH_O) begin
            if (eos) begin
              tok_end = 1'b1;
              fail    = 1'b1;
              st      = uats_pkg::ST_TRUNC;
            end else begin
              mode_nxt = uats_pkg::MODE_SSARG;
            end
          end else if (b == uats_pkg::CH_Q || b == uats_pkg::CH_R) begin
            tok_end = 1'b1;
            fail    = 1'b1;
            st      = uats_pkg::ST_PRIVATE;
          end else if (b == uats_pkg::CH_P || b == uats_pkg::CH_RBRK ||
                       b == uats_pkg::CH_CARET || b == uats_pkg::CH_UNDER) begin
            intro    = 1'b1;
            mode_nxt = uats_pkg::MODE_STR;
          end else if (b == uats_pkg::CH_X) begin
            intro       = 1'b1;
            mode_nxt    = uats_pkg::MODE_SOS;
            saw_esc_nxt = 1'b0;
          end else if (b == uats_pkg::CH_LBRK) begin
            intro    = 1'b1;
            mode_nxt = uats_pkg::MODE_CSI;
          end else begin
            tok_end = 1'b1;
          end
          if (intro && eos) begin
            tok_end = 1'b1;
          end
        end
        uats_pkg::MODE_SSARG: begin
          tok_end = 1'b1;
        end
        uats_pkg::MODE_STR: begin
          if (b < 8'h08 || b >= 8'h7F || (b >= 8'h0E && b <= 8'h1F) || eos) begin
            tok_end = 1'b1;
          end
        end
        uats_pkg::MODE_SOS: begin
          if (eos || (saw_esc_r && (b == uats_pkg::CH_X || b == uats_pkg::CH_BSL))) begin
            tok_end = 1'b1;
          end else begin
            saw_esc_nxt = (b == uats_pkg::CH_ESC);
          end
        end
        uats_pkg::MODE_CSI: begin
          if (eos || (b >= 8'h40 && b <= 8'h7E)) begin
            tok_end = 1'b1;
          end
        end
        default: begin
          // lead byte of a new token
          left_nxt    = 2'd0;
          saw_esc_nxt = 1'b0;
          mode_nxt    = uats_pkg::MODE_IDLE;
          priority if (b < 8'h20) begin
            if (b != uats_pkg::CH_ESC) begin
              kind    = uats_pkg::KIND_CTRL;
              tok_end = 1'b1;
            end else if (eos) begin
              tok_end = 1'b1;
              fail    = 1'b1;
              st      = uats_pkg::ST_TRUNC;
            end else begin
              mode_nxt = uats_pkg::MODE_ESC;
            end
          end else if (b < 8'h80) begin
            kind    = uats_pkg::KIND_ASCII;
            tok_end = 1'b1;
          end else if (b < 8'hC0) begin
            kind    = uats_pkg::KIND_UTF8;
            tok_end = 1'b1;
            fail    = 1'b1;
            st      = uats_pkg::ST_CONT_LEAD;
          end else if (b >= 8'hF8) begin
            kind    = uats_pkg::KIND_UTF8;
            tok_end = 1'b1;
            fail    = 1'b1;
            st      = uats_pkg::ST_BAD_LEAD;
          end else if (eos) begin
            kind    = uats_pkg::KIND_UTF8;
            tok_end = 1'b1;
            fail    = 1'b1;
            st      = uats_pkg::ST_TRUNC;
          end else begin
            kind     = uats_pkg::KIND_UTF8;
            mode_nxt = uats_pkg::MODE_UTF;
            left_nxt = (b >= 8'hF0) ? 2'd3 : (b >= 8'hE0) ? 2'd2 : 2'd1;
          end
        end
      endcase

      // every close returns to idle; an error starts dropping unless at the end mark
      if (tok_end) begin
        mode_nxt    = uats_pkg::MODE_IDLE;
        left_nxt    = 2'd0;
        saw_esc_nxt = 1'b0;
        if (fail) begin
          drop_nxt = ~eos;
        end
      end
    end

    res.data      = b;
    res.token_end = tok_end;
    res.kind      = kind;
    res.status    = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= uats_pkg::MODE_IDLE;
      left_r    <= 2'd0;
      saw_esc_r <= 1'b0;
      drop_r    <= 1'b0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      left_r    <= left_nxt;
      saw_esc_r <= saw_esc_nxt;
      drop_r    <= drop_nxt;
    end
  end

endmodule

// ----- rtl/utf8_ansi_token_splitter.sv -----
// channel | direction | ports
// --------+-----------+--------------------------------------------------------------
// in      | input     | in_valid, in_stall, in_byte, in_end_of_string
// out     | output    | out_valid, out_stall, out_byte, out_token_end, out_token_kind,
//         |           | out_status
//
// one byte per cycle sustained while out does not stall; a byte sits in the input register
// after its transfer, and the parser step loads its result into the result register,
// from which the result transfers out
// reset is synchronous on rst_n low: both registers empty, parser idle, not dropping
// a stall on out holds the result register; the input register then holds its
// byte and in_stall rises, unless that byte is being dropped and gives no result
module utf8_ansi_token_splitter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_token_end,
  output logic [1:0] out_token_kind,
  output logic [2:0] out_status
);

  // input register
  logic                s1_valid_r;
  uats_pkg::step_in_t  s1_data_r;

  // result register
  logic                out_valid_r;
  uats_pkg::result_t   out_data_r;

  logic                core_emit;
  uats_pkg::result_t   core_res;
  logic                out_free;
  logic                advance;

  // result register can load when empty or when its content is taken now
  assign out_free = !out_valid_r || !out_stall;
  // a byte leaves the input register when it needs no result slot or one is free
  assign advance  = s1_valid_r && (!core_emit || out_free);
  assign in_stall = s1_valid_r && !advance;

  uats_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .step_in (s1_data_r),
    .emit    (core_emit),
    .res     (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r.data <= in_byte;
      s1_data_r.eos  <= in_end_of_string;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && core_emit;
    end
  end

  // payload only loads on a real result transfer into the slot
  always_ff @(posedge clk) begin
    if (out_free && advance && core_emit) begin
      out_data_r <= core_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_data_r.data;
  assign out_token_end  = out_data_r.token_end;
  assign out_token_kind = out_data_r.kind;
  assign out_status     = out_data_r.status;

endmodule

// ----- test/tb_utf8_ansi_token_splitter.sv -----
`timescale 1ns / 1ps

module tb_utf8_ansi_token_splitter;
  import uats_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       in_end_of_string;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       out_token_end;
  logic [1:0] out_token_kind;
  logic [2:0] out_status;

  utf8_ansi_token_splitter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_token_end    (out_token_end),
    .out_token_kind   (out_token_kind),
    .out_status       (out_status)
  );

  // 20 ns period
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // token predictor: its own copy of the parser state
  // ---------------------------------------------------------------------------
  mode_t      pmode;
  logic [1:0] cont_left;     // utf8 continuation bytes still owed
  logic       sos_esc;       // last sos body byte was esc
  logic       dropping_q;    // swallowing bytes after an error

  result_t    expected_tokens[$];

  // idle control for each side, set per test
  bit tx_idle_on;
  bit rx_idle_on;

  int mismatches;
  int bytes_sent;
  int bytes_dropped;
  int strings_sent;
  int results_checked;
  int error_results;

  function automatic result_t make_res(logic [7:0] b, logic fin, logic [1:0] kind,
                                       logic [2:0] st);
    result_t r;
    r.data      = b;
    r.token_end = fin;
    r.kind      = kind;
    r.status    = st;
    return r;
  endfunction

  function automatic void to_idle();
    pmode     = MODE_IDLE;
    cont_left = 2'd0;
    sos_esc   = 1'b0;
  endfunction

  function automatic result_t close_token(logic [7:0] b, logic [1:0] kind);
    to_idle();
    return make_res(b, 1'b1, kind, ST_OK);
  endfunction

  // an error closes the token; unless the byte ends the string, drop until the end mark
  function automatic result_t error_token(logic [7:0] b, logic [1:0] kind, logic [2:0] st,
                                          logic eos);
    to_idle();
    dropping_q = !eos;
    return make_res(b, 1'b1, kind, st);
  endfunction

  // second byte of a variable-length escape: enter its body unless the string ends here
  function automatic result_t open_escape(logic [7:0] b, logic eos, mode_t m);
    pmode = m;
    if (eos) return close_token(b, KIND_ESC);
    return make_res(b, 1'b0, KIND_ESC, ST_OK);
  endfunction

  // returns 1 when the byte yields a result
  function automatic bit predict_token(input logic [7:0] b, input logic eos,
                                       output result_t r);
    logic str_end;
    r = '0;
    if (dropping_q) begin
      if (eos) begin
        dropping_q = 1'b0;
        to_idle();
      end
      return 1'b0;
    end

    case (pmode)
      MODE_UTF: begin
        // continuation bytes are counted, never checked
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) r = close_token(b, KIND_UTF8);
        else if (eos) r = error_token(b, KIND_UTF8, ST_TRUNC, eos);
        else r = make_res(b, 1'b0, KIND_UTF8, ST_OK);
        return 1'b1;
      end
      MODE_ESC: begin
        case (b)
          CH_N, CH_O: begin
            if (eos) r = error_token(b, KIND_ESC, ST_TRUNC, eos);
            else begin
              pmode = MODE_SSARG;
              r = make_res(b, 1'b0, KIND_ESC, ST_OK);
            end
          end
          CH_Q, CH_R:                        r = error_token(b, KIND_ESC, ST_PRIVATE, eos);
          CH_P, CH_RBRK, CH_CARET, CH_UNDER: r = open_escape(b, eos, MODE_STR);
          CH_X: begin
            sos_esc = 1'b0;
            r = open_escape(b, eos, MODE_SOS);
          end
          CH_LBRK:                           r = open_escape(b, eos, MODE_CSI);
          default:                           r = close_token(b, KIND_ESC);
        endcase
        return 1'b1;
      end
      MODE_SSARG: begin
        r = close_token(b, KIND_ESC);
        return 1'b1;
      end
      MODE_STR: begin
        // the terminating byte belongs to the token, so the esc of st closes it
        str_end = (b < 8'h08) || (b >= 8'h7F) || (b >= 8'h0E && b <= 8'h1F);
        if (str_end || eos) r = close_token(b, KIND_ESC);
        else r = make_res(b, 1'b0, KIND_ESC, ST_OK);
        return 1'b1;
      end
      MODE_SOS: begin
        if (eos || (sos_esc && (b == CH_X || b == CH_BSL))) r = close_token(b, KIND_ESC);
        else begin
          sos_esc = (b == CH_ESC);
          r = make_res(b, 1'b0, KIND_ESC, ST_OK);
        end
        return 1'b1;
      end
      MODE_CSI: begin
        if (eos || (b >= 8'h40 && b <= 8'h7E)) r = close_token(b, KIND_ESC);
        else r = make_res(b, 1'b0, KIND_ESC, ST_OK);
        return 1'b1;
      end
      default: ;
    endcase

    // idle: this byte leads a new token
    to_idle();
    if (b < 8'h20) begin
      if (b != CH_ESC) r = close_token(b, KIND_CTRL);
      else if (eos) r = error_token(b, KIND_ESC, ST_TRUNC, eos);
      else begin
        pmode = MODE_ESC;
        r = make_res(b, 1'b0, KIND_ESC, ST_OK);
      end
    end else if (b < 8'h80) begin
      r = close_token(b, KIND_ASCII);
    end else if (b < 8'hC0) begin
      r = error_token(b, KIND_UTF8, ST_CONT_LEAD, eos);
    end else if (b >= 8'hF8) begin
      r = error_token(b, KIND_UTF8, ST_BAD_LEAD, eos);
    end else if (eos) begin
      r = error_token(b, KIND_UTF8, ST_TRUNC, eos);
    end else begin
      // length comes from the lead byte alone
      pmode     = MODE_UTF;
      cont_left = (b >= 8'hF0) ? 2'd3 : (b >= 8'hE0) ? 2'd2 : 2'd1;
      r = make_res(b, 1'b0, KIND_UTF8, ST_OK);
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // idling: mostly short gaps, now and then a long one
  // ---------------------------------------------------------------------------
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int      gap;
    result_t res;
    gap = tx_idle_on ? idle_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      // junk on the payload while valid is low
      in_valid         <= 1'b0;
      in_byte          <= 8'($urandom);
      in_end_of_string <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_byte          <= b;
    in_end_of_string <= eos;
    // hold until the transfer happens
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    if (predict_token(b, eos, res)) expected_tokens.insert(expected_tokens.size(), res);
    else bytes_dropped++;
  endtask

  // one string: end mark on its last byte
  task automatic send_text(input byte_q_t t);
    foreach (t[i]) send_byte(t[i], i == t.size() - 1);
    strings_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stall, and the result check
  // ---------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_idle_on && $urandom_range(0, 99) < 35) begin
        out_stall <= 1'b1;
        repeat (idle_len()) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch on %s: got %0h want %0h after %0d results", what, got, want,
               results_checked);
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch("result with nothing pending", out_byte, 8'h00);
      end else begin
        want = expected_tokens.pop_front();
        results_checked++;
        if (want.status != ST_OK) error_results++;
        if (out_byte !== want.data)           report_mismatch("byte", out_byte, want.data);
        if (out_token_end !== want.token_end)
          report_mismatch("token end", 8'(out_token_end), 8'(want.token_end));
        if (out_token_kind !== want.kind)
          report_mismatch("kind", 8'(out_token_kind), 8'(want.kind));
        if (out_status !== want.status)
          report_mismatch("status", 8'(out_status), 8'(want.status));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // random text built from tokens
  // ---------------------------------------------------------------------------
  byte_q_t text_buf;

  function automatic void add_byte(logic [7:0] b);
    text_buf.insert(text_buf.size(), b);
  endfunction

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // a byte that ends a dcs/osc/pm/apc body
  function automatic logic [7:0] str_stop_byte();
    case ($urandom_range(0, 3))
      0:       return CH_ESC;
      1:       return 8'($urandom_range(8'h00, 8'h07));
      2:       return 8'($urandom_range(8'h0E, 8'h1F));
      default: return 8'($urandom_range(8'h7F, 8'hFF));
    endcase
  endfunction

  function automatic void add_token();
    int         pick;
    int         n;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      add_byte(8'($urandom_range(8'h20, 8'h7F)));
    end else if (pick < 28) begin
      b = 8'($urandom_range(8'h00, 8'h1F));
      add_byte((b == CH_ESC) ? 8'h0A : b);
    end else if (pick < 48) begin
      // utf8 character, 2 to 4 bytes
      n = $urandom_range(1, 3);
      case (n)
        1:       add_byte(8'($urandom_range(8'hC0, 8'hDF)));
        2:       add_byte(8'($urandom_range(8'hE0, 8'hEF)));
        default: add_byte(8'($urandom_range(8'hF0, 8'hF7)));
      endcase
      repeat (n) add_byte(cont_byte());
    end else if (pick < 53) begin
      // single shift with its argument
      add_byte(CH_ESC);
      add_byte($urandom_range(0, 1) ? CH_N : CH_O);
      add_byte(8'($urandom));
    end else if (pick < 61) begin
      // control string
      add_byte(CH_ESC);
      case ($urandom_range(0, 3))
        0:       add_byte(CH_P);
        1:       add_byte(CH_RBRK);
        2:       add_byte(CH_CARET);
        default: add_byte(CH_UNDER);
      endcase
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 4) == 0) add_byte(8'($urandom_range(8'h08, 8'h0D)));
        else add_byte(8'($urandom_range(8'h20, 8'h7E)));
      end
      add_byte(str_stop_byte());
    end else if (pick < 67) begin
      // sos string, esc inside the body not followed by a terminator
      add_byte(CH_ESC);
      add_byte(CH_X);
      repeat ($urandom_range(0, 5)) begin
        b = 8'($urandom);
        add_byte(b);
        if (b == CH_ESC) add_byte(8'($urandom_range(8'h41, 8'h57)));
      end
      add_byte(CH_ESC);
      add_byte($urandom_range(0, 1) ? CH_X : CH_BSL);
    end else if (pick < 77) begin
      // csi: parameters then a final byte
      add_byte(CH_ESC);
      add_byte(CH_LBRK);
      repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(8'h20, 8'h3F)));
      add_byte(8'($urandom_range(8'h40, 8'h7E)));
    end else if (pick < 83) begin
      // plain two-byte escape
      do b = 8'($urandom);
      while (b == CH_N || b == CH_O || b == CH_P || b == CH_Q || b == CH_R || b == CH_X ||
             b == CH_LBRK || b == CH_RBRK || b == CH_CARET || b == CH_UNDER);
      add_byte(CH_ESC);
      add_byte(b);
    end else if (pick < 90) begin
      // error tokens
      case ($urandom_range(0, 2))
        0: add_byte(8'($urandom_range(8'h80, 8'hBF)));
        1: add_byte(8'($urandom_range(8'hF8, 8'hFF)));
        default: begin
          add_byte(CH_ESC);
          add_byte($urandom_range(0, 1) ? CH_Q : CH_R);
        end
      endcase
    end else begin
      add_byte(8'($urandom));
    end
  endfunction

  // strings of whole tokens; some cut short so the end mark lands mid-token
  task automatic run_random_strings(input int count);
    int start;
    int cut;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      text_buf.delete();
      repeat ($urandom_range(1, 10)) add_token();
      if ($urandom_range(0, 99) < 15) begin
        cut = $urandom_range(1, text_buf.size());
        while (text_buf.size() > cut) void'(text_buf.pop_back());
      end
      send_text(text_buf);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // field extremes, utf8 lengths, lead errors and truncation
  task automatic test_plain_and_utf8();
    send_text({8'h00, 8'h7F, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF});
    send_text({8'hE2, 8'h82});     // end mark inside a 3-byte character
    send_text({8'h80, 8'h41});     // continuation as lead, rest dropped
    send_text({8'hFF});            // bad lead on the end mark drops nothing
  endtask

  // csi, osc and sos escapes plus the escape error cases
  task automatic test_escapes();
    send_text({CH_ESC, CH_Q, 8'h41});            // private use, then dropped
    send_text({CH_ESC, CH_N});                   // end mark before the shift argument
    send_text({CH_ESC});                         // end mark on a lone esc
    send_text({CH_ESC, CH_LBRK, 8'h31, 8'h6D});
    send_text({CH_ESC, CH_RBRK, 8'h30, CH_ESC}); // esc of st closes the string
    send_text({CH_ESC, CH_X, CH_ESC, CH_X});
  endtask

  task automatic test_random_text();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_random_strings(600);
  endtask

  // full rate both ways
  task automatic test_back_to_back();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_random_strings(200);
  endtask

  // full rate input against a stalling receiver
  task automatic test_output_pressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    run_random_strings(300);
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_byte          = 8'h00;
    in_end_of_string = 1'b0;
    tx_idle_on       = 1'b1;
    rx_idle_on       = 1'b1;
    dropping_q       = 1'b0;
    to_idle();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_plain_and_utf8();
    test_escapes();
    test_random_text();
    test_back_to_back();
    test_output_pressure();

    @(negedge clk);
    in_valid <= 1'b0;
    rx_idle_on = 1'b0;
    // let every pending result drain, then watch for strays
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d bytes in %0d strings, %0d dropped after errors", bytes_sent,
             strings_sent, bytes_dropped);
    $display("checked %0d results, %0d of them with an error status", results_checked,
             error_results);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
